// ----- src/omni4_pkg.sv -----
package omni4_pkg;

  // Pipeline and datapath sizing
  localparam int CORDIC_STAGES   = 16;
  localparam int SUM_W           = 34;
  localparam int CW              = 34;
  localparam int CFG_INDEX_WIDTH = 8;

  // Register map
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINEAR_GAIN  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEADING_GAIN = 8'd1;

  localparam logic [31:0] LINEAR_GAIN_RESET  = 32'd2317;
  localparam logic [31:0] HEADING_GAIN_RESET = 32'd2731;

  // round(2^32 / (2*pi)), turns per radian in Q32
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  // CORDIC gain compensation, Q4.30
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] wheel1_angle;
    logic signed [31:0] wheel2_angle;
    logic signed [31:0] wheel3_angle;
    logic signed [31:0] wheel4_angle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] heading;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic               saturated;
  } out_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933405;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/omni4_forward_kinematics_unit.sv -----
// Four-wheel omni base forward kinematics, fully pipelined.
//
// Input channel (in_valid/in_ready/in_data): one beat carries the four
// accumulated wheel angles, signed Q16.16 radians.
// Output channel (out_valid/out_ready/out_data): one beat per input beat,
// in order: robot-frame x/y, heading, world-frame x/y and a clip flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the
// linear and heading gains; cfg_ready is always high, unknown indexes are
// dropped. Write gains only while no beat is in flight.
//
// Throughput: one beat per cycle while the receiver keeps out_ready high.
// The CORDIC rotation uses one register stage per iteration.
// Each stage holds its beat while the stage after it is full, so a stalled
// receiver fills bubbles first; in_ready drops only once every stage and
// the output register hold a beat.
// Reset (rst, synchronous) empties the pipeline and restores both gains.
module omni4_forward_kinematics_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  omni4_pkg::in_t                       in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output omni4_pkg::out_t                      out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [omni4_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [31:0]                          cfg_data
);

  localparam int N  = omni4_pkg::CORDIC_STAGES;
  localparam int CW = omni4_pkg::CW;

  typedef struct packed {
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] hd;
    logic               flag;
  } carry_t;

  typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_t;

  // Gain registers
  logic [31:0] linear_gain;
  logic [31:0] heading_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain  <= omni4_pkg::LINEAR_GAIN_RESET;
      heading_gain <= omni4_pkg::HEADING_GAIN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == omni4_pkg::REG_LINEAR_GAIN) linear_gain <= cfg_data;
      if (cfg_index == omni4_pkg::REG_HEADING_GAIN) heading_gain <= cfg_data;
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads
  logic a_v, b_v, c_v, d_v, q_v, m_v;
  logic a_en, b_en, c_en, d_en, q_en, m_en, o_en;
  logic [N-1:0] cr_v;
  logic [N-1:0] cr_en;

  assign o_en     = !out_valid || out_ready;
  assign m_en     = !m_v || o_en;
  assign q_en     = !q_v || m_en;
  assign d_en     = !d_v || cr_en[0];
  assign c_en     = !c_v || d_en;
  assign b_en     = !b_v || c_en;
  assign a_en     = !a_v || b_en;
  assign in_ready = a_en;

  // Stage A: wheel sums, split into sign and magnitude
  logic signed [omni4_pkg::SUM_W-1:0] w1, w2, w3, w4;
  logic signed [omni4_pkg::SUM_W-1:0] sum_next [3];
  logic [omni4_pkg::SUM_W-1:0] a_mag [3];
  logic                        a_neg [3];

  assign w1 = omni4_pkg::SUM_W'(in_data.wheel1_angle);
  assign w2 = omni4_pkg::SUM_W'(in_data.wheel2_angle);
  assign w3 = omni4_pkg::SUM_W'(in_data.wheel3_angle);
  assign w4 = omni4_pkg::SUM_W'(in_data.wheel4_angle);
  assign sum_next[0] = w3 + w4 - w1 - w2;
  assign sum_next[1] = w2 + w3 - w1 - w4;
  assign sum_next[2] = w1 + w2 + w3 + w4;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (a_en) a_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      for (int k = 0; k < 3; k++) begin
        a_neg[k] <= sum_next[k][omni4_pkg::SUM_W-1];
        a_mag[k] <= sum_next[k][omni4_pkg::SUM_W-1] ? omni4_pkg::SUM_W'(-sum_next[k])
                                                    : omni4_pkg::SUM_W'(sum_next[k]);
      end
    end
  end

  // Stage B: magnitude times gain, high and low halves of the gain
  logic [49:0] b_hi [3];
  logic [49:0] b_lo [3];
  logic        b_neg [3];
  logic [31:0] gain_sel [3];

  assign gain_sel[0] = linear_gain;
  assign gain_sel[1] = linear_gain;
  assign gain_sel[2] = heading_gain;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (b_en) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      for (int k = 0; k < 3; k++) begin
        b_hi[k]  <= 50'(a_mag[k]) * 50'(gain_sel[k][31:16]);
        b_lo[k]  <= 50'(a_mag[k]) * 50'(gain_sel[k][15:0]);
        b_neg[k] <= a_neg[k];
      end
    end
  end

  // Stage C: round the fraction, apply sign, saturate
  logic signed [31:0] c_val_next [3];
  logic               c_flag_next;
  carry_t             c_carry;

  always_comb begin
    logic [50:0] p;
    c_flag_next = 1'b0;
    for (int k = 0; k < 3; k++) begin
      p = 51'(b_hi[k]) + ((51'(b_lo[k]) + 51'h8000) >> 16);
      if (b_neg[k]) begin
        if (p > 51'h80000000) begin
          c_val_next[k] = 32'sh80000000;
          c_flag_next   = 1'b1;
        end else begin
          c_val_next[k] = 32'(-p);
        end
      end else begin
        if (p > 51'h7FFFFFFF) begin
          c_val_next[k] = 32'sh7FFFFFFF;
          c_flag_next   = 1'b1;
        end else begin
          c_val_next[k] = 32'(p);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (c_en) c_v <= b_v;
  end

  always_ff @(posedge clk) begin
    if (c_en) begin
      c_carry.lx   <= c_val_next[0];
      c_carry.ly   <= c_val_next[1];
      c_carry.hd   <= c_val_next[2];
      c_carry.flag <= c_flag_next;
    end
  end

  // Stage D: heading to phase in 2^-32 turn
  logic signed [62:0] phase_prod;
  logic [31:0]        d_phase;
  carry_t             d_carry;

  assign phase_prod = 63'(c_carry.hd) * 63'($signed({1'b0, omni4_pkg::INV_TWO_PI}));

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (d_en) d_v <= c_v;
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_phase <= phase_prod[47:16];
      d_carry <= c_carry;
    end
  end

  // CORDIC rotation, one iteration per stage
  logic [31:0] d_off;
  assign d_off = d_phase + 32'h20000000;

  logic signed [CW-1:0] cr_x [N];
  logic signed [CW-1:0] cr_y [N];
  logic signed [CW-1:0] cr_z [N];
  quad_t                cr_q [N];
  carry_t               cr_c [N];

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [CW-1:0] xi, yi, zi, dx, dy, atn;
    quad_t                qi;
    carry_t               ci;
    logic                 vi;

    if (i == 0) begin : g_first
      assign vi = d_v;
      assign xi = omni4_pkg::CORDIC_X0;
      assign yi = '0;
      assign zi = $signed({4'b0000, d_off[29:0]}) - 34'sh20000000;
      assign qi = quad_t'(d_off[31:30]);
      assign ci = d_carry;
    end else begin : g_rest
      assign vi = cr_v[i-1];
      assign xi = cr_x[i-1];
      assign yi = cr_y[i-1];
      assign zi = cr_z[i-1];
      assign qi = cr_q[i-1];
      assign ci = cr_c[i-1];
    end

    if (i == N - 1) begin : g_last_en
      assign cr_en[i] = !cr_v[i] || q_en;
    end else begin : g_mid_en
      assign cr_en[i] = !cr_v[i] || cr_en[i+1];
    end

    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign atn = CW'(omni4_pkg::atan_turn(5'(i)));

    always_ff @(posedge clk) begin
      if (rst) cr_v[i] <= 1'b0;
      else if (cr_en[i]) cr_v[i] <= vi;
    end

    always_ff @(posedge clk) begin
      if (cr_en[i]) begin
        // zero residual rotates in the positive direction
        if (!zi[CW-1]) begin
          cr_x[i] <= xi - dx;
          cr_y[i] <= yi + dy;
          cr_z[i] <= zi - atn;
        end else begin
          cr_x[i] <= xi + dx;
          cr_y[i] <= yi - dy;
          cr_z[i] <= zi + atn;
        end
        cr_q[i] <= qi;
        cr_c[i] <= ci;
      end
    end
  end

  // Stage Q: quadrant fold into cosine and sine
  logic signed [CW-1:0] q_cos, q_sin, cos_next, sin_next;
  carry_t               q_carry;

  always_comb begin
    case (cr_q[N-1])
      QUAD_0: begin
        cos_next = cr_x[N-1];
        sin_next = cr_y[N-1];
      end
      QUAD_90: begin
        cos_next = -cr_y[N-1];
        sin_next = cr_x[N-1];
      end
      QUAD_180: begin
        cos_next = -cr_x[N-1];
        sin_next = -cr_y[N-1];
      end
      default: begin
        cos_next = cr_y[N-1];
        sin_next = -cr_x[N-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) q_v <= 1'b0;
    else if (q_en) q_v <= cr_v[N-1];
  end

  always_ff @(posedge clk) begin
    if (q_en) begin
      q_cos   <= cos_next;
      q_sin   <= sin_next;
      q_carry <= cr_c[N-1];
    end
  end

  // Stage M: rotation products
  logic signed [65:0] m_xc, m_ys, m_xs, m_yc;
  carry_t             m_carry;

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (m_en) m_v <= q_v;
  end

  always_ff @(posedge clk) begin
    if (m_en) begin
      m_xc    <= 66'(q_carry.lx) * 66'(q_cos);
      m_ys    <= 66'(q_carry.ly) * 66'(q_sin);
      m_xs    <= 66'(q_carry.lx) * 66'(q_sin);
      m_yc    <= 66'(q_carry.ly) * 66'(q_cos);
      m_carry <= q_carry;
    end
  end

  // Output stage: round, shift back to Q16.16, saturate
  logic signed [66:0] wx_sum, wy_sum, wx_sh, wy_sh;
  logic signed [31:0] wx_next, wy_next;
  logic               wx_clip, wy_clip;

  assign wx_sum = 67'(m_xc) - 67'(m_ys) + 67'sd536870912;
  assign wy_sum = 67'(m_xs) + 67'(m_yc) + 67'sd536870912;
  assign wx_sh  = wx_sum >>> 30;
  assign wy_sh  = wy_sum >>> 30;

  always_comb begin
    wx_clip = 1'b1;
    wy_clip = 1'b1;
    if (wx_sh > 67'sd2147483647) wx_next = 32'sh7FFFFFFF;
    else if (wx_sh < -67'sd2147483648) wx_next = 32'sh80000000;
    else begin
      wx_next = 32'(wx_sh);
      wx_clip = 1'b0;
    end
    if (wy_sh > 67'sd2147483647) wy_next = 32'sh7FFFFFFF;
    else if (wy_sh < -67'sd2147483648) wy_next = 32'sh80000000;
    else begin
      wy_next = 32'(wy_sh);
      wy_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (o_en) out_valid <= m_v;
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      out_data.local_x   <= m_carry.lx;
      out_data.local_y   <= m_carry.ly;
      out_data.heading   <= m_carry.hd;
      out_data.world_x   <= wx_next;
      out_data.world_y   <= wy_next;
      out_data.saturated <= m_carry.flag || wx_clip || wy_clip;
    end
  end

`ifndef SYNTH
  // input backpressure only when every stage is occupied and the sink stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (a_v && out_valid && !out_ready))
    else $error("in_ready low with room in the pipeline");

  // a beat leaving the product stage lands in the output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (m_v && o_en) |=> out_valid)
    else $error("product stage beat lost");

  // a blocked phase stage keeps its beat
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (d_v && !d_en) |=> (d_v && $stable(d_phase)))
    else $error("phase stage changed while stalled");
`endif

endmodule

// ----- sim/tb_omni4_forward_kinematics_unit.sv -----
module tb_omni4_forward_kinematics_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam logic [omni4_pkg::CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = '1;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES = 7;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ATAN_TURN [32] = '{
    536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  // Pose predictor plus the in-order store of poses still due
  class pose_tracker;
    logic [31:0] lin_gain;
    logic [31:0] hdg_gain;
    omni4_pkg::out_t poses_due[$];
    int errors;

    function new();
      lin_gain = omni4_pkg::LINEAR_GAIN_RESET;
      hdg_gain = omni4_pkg::HEADING_GAIN_RESET;
      errors = 0;
    endfunction

    function void write_gain(logic [omni4_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
      case (idx)
        omni4_pkg::REG_LINEAR_GAIN: lin_gain = val;
        omni4_pkg::REG_HEADING_GAIN: hdg_gain = val;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return poses_due.size();
    endfunction

    function longint clip32(longint v, inout bit clip);
      if (v > SAT_HI) begin
        clip = 1'b1;
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        clip = 1'b1;
        return SAT_LO;
      end
      return v;
    endfunction

    // Q16.16 gain: magnitude rounded half away from zero, sign applied after
    function longint scale(longint sum, logic [31:0] g, inout bit clip);
      longint mag;
      longint p;
      mag = (sum < 0) ? -sum : sum;
      p = mag * longint'({48'h0, g[31:16]})
        + ((mag * longint'({48'h0, g[15:0]}) + 64'sd32768) >>> 16);
      if (sum < 0) begin
        if (p > -SAT_LO) begin
          clip = 1'b1;
          return SAT_LO;
        end
        return -p;
      end
      return clip32(p, clip);
    endfunction

    // Heading to turns, then rotation-mode CORDIC with quadrant folding
    function void sin_cos(longint h, output longint s, output longint c);
      longint prod;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      logic [31:0] phase;
      logic [31:0] off;
      int i;
      prod = h * longint'({34'h0, omni4_pkg::INV_TWO_PI});
      phase = prod[47:16];
      off = phase + 32'h2000_0000;
      z = longint'({34'h0, off[29:0]}) - 64'sd536870912;
      x = 64'sd652032874;
      y = 0;
      for (i = 0; i < omni4_pkg::CORDIC_STAGES; i++) begin
        dx = y >>> (i % 32);
        dy = x >>> (i % 32);
        // zero residual rotates the positive way
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_TURN[i % 32];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_TURN[i % 32];
        end
      end
      case (off[31:30])
        2'd0: begin
          c = x;
          s = y;
        end
        2'd1: begin
          c = -y;
          s = x;
        end
        2'd2: begin
          c = -x;
          s = -y;
        end
        default: begin
          c = y;
          s = -x;
        end
      endcase
    endfunction

    function void note_wheels(omni4_pkg::in_t w);
      longint w1;
      longint w2;
      longint w3;
      longint w4;
      longint lx;
      longint ly;
      longint hd;
      longint s;
      longint c;
      bit clip;
      omni4_pkg::out_t pose;
      w1 = longint'($signed(w.wheel1_angle));
      w2 = longint'($signed(w.wheel2_angle));
      w3 = longint'($signed(w.wheel3_angle));
      w4 = longint'($signed(w.wheel4_angle));
      clip = 1'b0;
      lx = scale(-w1 - w2 + w3 + w4, lin_gain, clip);
      ly = scale(-w1 + w2 + w3 - w4, lin_gain, clip);
      hd = scale(w1 + w2 + w3 + w4, hdg_gain, clip);
      sin_cos(hd, s, c);
      pose.local_x = lx[31:0];
      pose.local_y = ly[31:0];
      pose.heading = hd[31:0];
      pose.world_x = 32'(clip32((lx * c - ly * s + 64'sd536870912) >>> 30, clip));
      pose.world_y = 32'(clip32((lx * s + ly * c + 64'sd536870912) >>> 30, clip));
      pose.saturated = clip;
      poses_due.push_back(pose);
    endfunction

    function void cmp(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_pose(omni4_pkg::out_t got);
      omni4_pkg::out_t want;
      if (poses_due.size() == 0) begin
        $error("result beat with no pose pending");
        errors++;
        return;
      end
      want = poses_due.pop_front();
      cmp("local_x", want.local_x, got.local_x);
      cmp("local_y", want.local_y, got.local_y);
      cmp("heading", want.heading, got.heading);
      cmp("world_x", want.world_x, got.world_x);
      cmp("world_y", want.world_y, got.world_y);
      cmp("saturated", 32'(want.saturated), 32'(got.saturated));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  omni4_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  omni4_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [omni4_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pose_tracker track = new();
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_out_req = 1'b0;

  omni4_forward_kinematics_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic omni4_pkg::in_t wheels(input logic [31:0] a, b, c, d);
    return {a, b, c, d};
  endfunction

  // Mix of extremes, full-range and small angles
  function automatic logic [31:0] rand_angle();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: r = r[1] ? (r[0] ? 32'h7FFF_FFFF : 32'h8000_0000) : {32{r[0]}};
      1, 2, 3, 4: ;
      default: r = {{12{r[19]}}, r[19:0]};
    endcase
    return r;
  endfunction

  // One input beat, with a random gap before it
  task automatic send_wheels(input omni4_pkg::in_t w);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track.note_wheels(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (track.outstanding() != 0) @(posedge clk);
  endtask

  // Both gains plus a write to an unmapped index, which must be dropped
  task automatic program_gains(input logic [31:0] lin, input logic [31:0] hdg);
    logic [omni4_pkg::CFG_INDEX_WIDTH-1:0] idx [3];
    logic [31:0] val [3];
    int k;
    idx = '{omni4_pkg::REG_LINEAR_GAIN, omni4_pkg::REG_HEADING_GAIN, REG_UNMAPPED};
    val = '{lin, hdg, $urandom};
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      track.write_gain(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random back-pressure, plus one long hold on request
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) track.check_pose(out_data);
      if (hold_out_req) begin
        hold_left = 120;
        hold_out_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] lin_set [NUM_PHASES];
    logic [31:0] hdg_set [NUM_PHASES];
    int p;
    int q;
    int n;

    lin_set = '{omni4_pkg::LINEAR_GAIN_RESET, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0,
                $urandom_range(0, 32'h3FFFF), $urandom, omni4_pkg::LINEAR_GAIN_RESET};
    hdg_set = '{omni4_pkg::HEADING_GAIN_RESET, 32'h0001_8000, 32'hFFFF_FFFF, 32'h0,
                $urandom_range(0, 32'h3FFFF), $urandom_range(0, 32'hFFFF),
                omni4_pkg::HEADING_GAIN_RESET};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, sign patterns, zero heading, a sweep of headings
    src_idle_pct = 31;
    snk_idle_pct = 76;
    send_wheels(wheels(32'h0, 32'h0, 32'h0, 32'h0));
    send_wheels(wheels(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_wheels(wheels(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_wheels(wheels(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_wheels(wheels(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_wheels(wheels(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_wheels(wheels(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_wheels(wheels(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1));
    send_wheels(wheels(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    for (q = -4; q < 4; q++) begin
      send_wheels(wheels(q * 300000 + 50000, q * 300000 - 70000,
                         q * 300000 + 120000, q * 300000));
    end

    // Random phases, one gain setting each
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        program_gains(lin_set[p], hdg_set[p]);
      end
      if (p < 2) begin
        src_idle_pct = 31;
        snk_idle_pct = 76;
      end else if (p < 4) begin
        src_idle_pct = 76;
        snk_idle_pct = 31;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long result stall while beats keep coming, to back up the pipe
        if (p == 5 && n == 20) hold_out_req = 1'b1;
        send_wheels(wheels(rand_angle(), rand_angle(), rand_angle(), rand_angle()));
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (track.errors == 0 && track.outstanding() == 0) begin
      $display("omni4_forward_kinematics_unit: match");
    end else begin
      $display("omni4_forward_kinematics_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("omni4_forward_kinematics_unit: mismatch");
    $finish;
  end

endmodule
